// ===== design/layer_alpha_composite_convert_unit_assert.svh =====
// assertion helpers shared by lacc_queue and lacc_luma
// both expect clk and rst (synchronous, active high) in scope
`ifndef LAYER_ALPHA_COMPOSITE_CONVERT_UNIT_ASSERT_SVH
`define LAYER_ALPHA_COMPOSITE_CONVERT_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define LACC_ASSERT_SAME(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("lacc check failed");

// condition holds in the cycle after the trigger
`define LACC_ASSERT_NEXT(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("lacc check failed");

`endif

// ===== design/lacc_pkg.sv =====
package lacc_pkg;

  // request queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // config register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PACK_ROW   = 2'd2;

  localparam logic [31:0] BG_RESET     = 32'hFF00_0000;
  localparam logic [7:0]  THRESH_RESET = 8'd128;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // luma weights, sum fits 18 bits (max 255000)
  localparam int          SUM_W  = 18;
  localparam logic [SUM_W-1:0] LUMA_R = 18'd299;
  localparam logic [SUM_W-1:0] LUMA_G = 18'd587;
  localparam logic [SUM_W-1:0] LUMA_B = 18'd114;

  // divide by 1000: ceil(2^28 / 1000), exact for sums up to 255000
  localparam int          RECIP_W    = 19;
  localparam logic [RECIP_W-1:0] GRAY_RECIP = 19'd268436;
  localparam int          GRAY_SHIFT = 28;
  localparam int          PROD_W     = SUM_W + RECIP_W;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    KIND_KEEP,
    KIND_TAKE,
    KIND_MIX
  } blend_kind_t;

  // one classified layer request
  typedef struct packed {
    logic [31:0] pixel;
    blend_kind_t kind;
    logic        last;
    logic        row_flush;
    logic        image_end;
  } item_t;

  // one finished pixel heading for the luma stages
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_flush;
    logic       image_end;
  } pixel_t;

  // (fg*a + bg*(255-a)) / 255, the divide done as (x + (x>>8) + 1) >> 8
  function automatic logic [7:0] blend_chan(input logic [7:0] fg,
                                            input logic [7:0] bg,
                                            input logic [7:0] a);
    logic [15:0] x;
    logic [16:0] t;
    x = ({8'd0, fg} * {8'd0, a}) + ({8'd0, bg} * {8'd0, ~a});
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ===== design/layer_alpha_composite_convert_unit.sv =====
// channel   | dir | handshake          | contents
// s_*       | in  | s_tvalid/s_tready  | tdata src_argb, tlast last_layer,
//           |     |                    | tuser end_of_row, end_of_image
// m_*       | out | m_tvalid/m_tready  | tdata red..packed_byte, tuser byte_ready
// cfg_*     | in  | cfg_we             | cfg_index, cfg_data
//
// one layer request per cycle while the queue has room; running_color closes the blend recurrence
// a top-layer request's result passes the queue, the blend output register, s3, s4 and the
// output register; back pressure holds the back stages; the 4-deep queue keeps s_tready up
// until it fills, so input never waits on m_tready combinationally
// rst is synchronous, active high; config is back at its reset values
module layer_alpha_composite_convert_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] src_argb
  input  logic [lacc_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  // [0] end_of_row, [1] end_of_image
  input  logic [lacc_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha_out, [39:32] gray,
  // [40] mono_bit, [48:41] packed_byte, [55:49] zero
  output logic [lacc_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [0] byte_ready
  output logic                              m_tuser,
  input  logic                              cfg_we,
  input  logic [lacc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data
);
  import lacc_pkg::*;

  // config registers
  logic [31:0] background;
  logic [7:0]  threshold;
  logic        pack_per_row;

  // front to queue
  logic        q_ready;
  logic        push;
  item_t       push_item;

  // queue to blend
  logic        q_valid;
  item_t       q_item;
  logic        pop;

  // blend to luma
  logic        px_valid;
  pixel_t      px;
  logic        adv;

  // unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      background   <= BG_RESET;
      threshold    <= THRESH_RESET;
      pack_per_row <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BACKGROUND: background   <= cfg_data;
        REG_THRESHOLD:  threshold    <= cfg_data[7:0];
        REG_PACK_ROW:   pack_per_row <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // classify layer alpha, mask row/image marks on inner layers
  lacc_front u_front (
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .s_tuser      (s_tuser),
    .pack_per_row (pack_per_row),
    .q_ready      (q_ready),
    .push         (push),
    .push_item    (push_item)
  );

  // decouples the input side from output back pressure
  lacc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .in_ready  (q_ready),
    .pop       (pop),
    .out_valid (q_valid),
    .out_item  (q_item)
  );

  // running colour over the layers of one pixel
  lacc_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .background (background),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .adv        (adv),
    .pop        (pop),
    .px_valid   (px_valid),
    .px         (px)
  );

  // gray, mono bit, byte packing and the output register
  lacc_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .px_valid  (px_valid),
    .px        (px),
    .threshold (threshold),
    .adv       (adv),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== design/lacc_front.sv =====
module lacc_front (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lacc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  input  logic [lacc_pkg::IN_USER_W-1:0]  s_tuser,
  input  logic                            pack_per_row,
  input  logic                            q_ready,
  output logic                            push,
  output lacc_pkg::item_t                 push_item
);
  import lacc_pkg::*;

  logic [7:0] alpha;

  assign alpha    = s_tdata[31:24];
  assign s_tready = q_ready;
  assign push     = s_tvalid & q_ready;

  always_comb begin
    push_item.pixel = s_tdata;
    if (alpha == 8'd0) begin
      push_item.kind = KIND_KEEP;
    end else if (alpha == ALPHA_OPAQUE) begin
      push_item.kind = KIND_TAKE;
    end else begin
      push_item.kind = KIND_MIX;
    end
    push_item.last      = s_tlast;
    // row and image marks only count on the top layer
    push_item.row_flush = s_tlast & s_tuser[0] & pack_per_row;
    push_item.image_end = s_tlast & s_tuser[1];
  end

endmodule

// ===== design/lacc_queue.sv =====
module lacc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lacc_pkg::item_t  push_item,
  output logic             in_ready,
  input  logic             pop,
  output logic             out_valid,
  output lacc_pkg::item_t  out_item
);
  import lacc_pkg::*;

  item_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign in_ready  = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

`include "layer_alpha_composite_convert_unit_assert.svh"

  `LACC_ASSERT_SAME(a_count_bound, 1'b1, count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
  `LACC_ASSERT_SAME(a_no_push_full, !in_ready, !push)
  `LACC_ASSERT_NEXT(a_fill_step, push && !pop, count == $past(count) + 1'b1)
  `LACC_ASSERT_NEXT(a_drain_step, pop && !push, count == $past(count) - 1'b1)

endmodule

// ===== design/lacc_blend.sv =====
module lacc_blend (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      background,
  input  logic             q_valid,
  input  lacc_pkg::item_t  q_item,
  input  logic             adv,
  output logic             pop,
  output logic             px_valid,
  output lacc_pkg::pixel_t px
);
  import lacc_pkg::*;

  logic [31:0] running_color;
  logic        pixel_start;
  logic [31:0] base;
  logic [31:0] mixed;
  logic [7:0]  a;

  assign pop  = q_valid & adv;
  assign base = pixel_start ? background : running_color;
  assign a    = q_item.pixel[31:24];

  always_comb begin
    case (q_item.kind)
      KIND_KEEP: mixed = base;
      KIND_TAKE: mixed = q_item.pixel;
      KIND_MIX: begin
        mixed = {ALPHA_OPAQUE,
                 blend_chan(q_item.pixel[23:16], base[23:16], a),
                 blend_chan(q_item.pixel[15:8], base[15:8], a),
                 blend_chan(q_item.pixel[7:0], base[7:0], a)};
      end
      default: mixed = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_color <= '0;
      pixel_start   <= 1'b1;
      px_valid      <= 1'b0;
    end else begin
      if (pop) begin
        running_color <= mixed;
        pixel_start   <= q_item.last;
      end
      if (adv) begin
        px_valid <= pop & q_item.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px.alpha     <= mixed[31:24];
      px.red       <= mixed[23:16];
      px.green     <= mixed[15:8];
      px.blue      <= mixed[7:0];
      px.row_flush <= q_item.row_flush;
      px.image_end <= q_item.image_end;
    end
  end

endmodule

// ===== design/lacc_luma.sv =====
module lacc_luma (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            px_valid,
  input  lacc_pkg::pixel_t                px,
  input  logic [7:0]                      threshold,
  output logic                            adv,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lacc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser
);
  import lacc_pkg::*;

  logic              s3_valid;
  pixel_t            s3_px;
  logic [SUM_W-1:0]  s3_sum;
  logic              s4_valid;
  pixel_t            s4_px;
  logic [7:0]        s4_gray;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic              mono_now;
  logic [7:0]        buf_new;
  logic              flush_now;
  logic              load;

  logic [2:0]        bit_position;
  logic [7:0]        pack_buffer;

  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic [7:0]        out_alpha;
  logic [7:0]        out_gray;
  logic              out_mono;
  logic [7:0]        out_packed;

  assign adv  = !m_tvalid || m_tready;
  assign load = adv && s4_valid;

  assign sum = ({10'd0, px.red} * LUMA_R) + ({10'd0, px.green} * LUMA_G)
             + ({10'd0, px.blue} * LUMA_B);
  assign prod = {{RECIP_W{1'b0}}, s3_sum} * {{SUM_W{1'b0}}, GRAY_RECIP};

  assign mono_now  = (s4_gray < threshold);
  assign buf_new   = pack_buffer | ({7'd0, mono_now} << (~bit_position));
  assign flush_now = (bit_position == 3'd7) || s4_px.image_end || s4_px.row_flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      bit_position <= '0;
      pack_buffer  <= '0;
      m_tuser      <= 1'b0;
    end else begin
      if (adv) begin
        s3_valid <= px_valid;
        s4_valid <= s3_valid;
        m_tvalid <= s4_valid;
      end
      if (load) begin
        m_tuser <= flush_now;
        if (flush_now) begin
          bit_position <= '0;
          pack_buffer  <= '0;
        end else begin
          bit_position <= bit_position + 1'b1;
          pack_buffer  <= buf_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_px   <= px;
      s3_sum  <= sum;
      s4_px   <= s3_px;
      s4_gray <= prod[GRAY_SHIFT +: 8];
    end
    if (load) begin
      out_red    <= s4_px.red;
      out_green  <= s4_px.green;
      out_blue   <= s4_px.blue;
      out_alpha  <= s4_px.alpha;
      out_gray   <= s4_gray;
      out_mono   <= mono_now;
      out_packed <= flush_now ? buf_new : 8'd0;
    end
  end

  assign m_tdata = {7'd0, out_packed, out_mono, out_gray,
                    out_alpha, out_blue, out_green, out_red};

`include "layer_alpha_composite_convert_unit_assert.svh"

  `LACC_ASSERT_SAME(a_pad_zero, m_tvalid && !m_tuser, out_packed == 8'd0)
  `LACC_ASSERT_NEXT(a_flush_clears, load && flush_now, bit_position == 3'd0 && pack_buffer == 8'd0)
  `LACC_ASSERT_NEXT(a_bit_step, load && !flush_now, bit_position == $past(bit_position) + 1'b1)

endmodule

// ===== sim/tb_layer_alpha_composite_convert_unit.sv =====
module tb_layer_alpha_composite_convert_unit;
  import lacc_pkg::*;

  // index that maps to no register, writes to it must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  // a top-layer request's result crosses the queue and pipe registers, give it margin
  localparam int SETTLE_CYCLES = 16;
  localparam int TARGET_ITEMS = 1225;
  localparam int QUIET_ITEMS = 1050;
  localparam int CYCLE_LIMIT = 400000;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   s_tlast;
  logic [IN_USER_W-1:0]   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tuser;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_data;

  // one finished pixel as the block should report it
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] gray;
    logic       mono;
    logic [7:0] packed_bits;
    logic       ready;
  } pixel_result_t;

  // tracks compositing and mono packing, holds the pixels still owed
  class composite_tracker;
    logic [31:0] start_color;
    logic [7:0]  threshold;
    logic        row_pack;
    logic [31:0] blend_acc;
    logic        pixel_start;
    logic [2:0]  bit_pos;
    logic [7:0]  mono_acc;
    pixel_result_t pending[$];
    int mismatches;
    int pixels_checked;
    int bytes_checked;

    function new();
      start_color = BG_RESET;
      threshold = THRESH_RESET;
      row_pack = 1'b0;
      blend_acc = '0;
      pixel_start = 1'b1;
      bit_pos = '0;
      mono_acc = '0;
      mismatches = 0;
      pixels_checked = 0;
      bytes_checked = 0;
    endfunction

    // only the register's own width is kept, unknown indexes drop the write
    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_BACKGROUND: start_color = val;
        REG_THRESHOLD:  threshold = val[7:0];
        REG_PACK_ROW:   row_pack = val[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] mix_chan(int unsigned fg, int unsigned bg, int unsigned a);
      int unsigned q;
      q = (fg * a + bg * (255 - a)) / 255;
      return q[7:0];
    endfunction

    // alpha 0 keeps, alpha 255 takes, anything between mixes and goes opaque
    function logic [31:0] over(logic [31:0] under, logic [31:0] top);
      int unsigned a;
      a = top[31:24];
      if (a == 0) return under;
      if (a == 255) return top;
      return {ALPHA_OPAQUE,
              mix_chan(top[23:16], under[23:16], a),
              mix_chan(top[15:8], under[15:8], a),
              mix_chan(top[7:0], under[7:0], a)};
    endfunction

    function void note_layer(logic [31:0] px, logic last, logic eor, logic eoi);
      pixel_result_t res;
      int unsigned luma;
      logic flush;
      if (pixel_start) blend_acc = start_color;
      blend_acc = over(blend_acc, px);
      pixel_start = last;
      // inner layers carry no result, their row and image marks are ignored
      if (!last) return;
      res.red = blend_acc[23:16];
      res.green = blend_acc[15:8];
      res.blue = blend_acc[7:0];
      res.alpha = blend_acc[31:24];
      luma = (299 * res.red + 587 * res.green + 114 * res.blue) / 1000;
      res.gray = luma[7:0];
      res.mono = (luma < threshold);
      mono_acc = mono_acc | ({7'd0, res.mono} << (3'd7 - bit_pos));
      flush = (bit_pos == 3'd7) || eoi || (row_pack && eor);
      res.ready = flush;
      // byte reads as zero unless flushed with this pixel
      res.packed_bits = flush ? mono_acc : 8'd0;
      if (flush) begin
        mono_acc = '0;
        bit_pos = '0;
      end else begin
        bit_pos = bit_pos + 3'd1;
      end
      pending.push_back(res);
    endfunction

    function void field_ok(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(logic [OUT_DATA_W-1:0] data, logic user);
      pixel_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h/%b", $time, data, user);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      field_ok("red", want.red, data[7:0]);
      field_ok("green", want.green, data[15:8]);
      field_ok("blue", want.blue, data[23:16]);
      field_ok("alpha_out", want.alpha, data[31:24]);
      field_ok("gray", want.gray, data[39:32]);
      field_ok("mono_bit", want.mono, data[40]);
      field_ok("packed_byte", want.packed_bits, data[48:41]);
      field_ok("byte_ready", want.ready, user);
      pixels_checked++;
      if (want.ready) bytes_checked++;
    endfunction
  endclass

  composite_tracker tracker;
  bit idle_on;
  int items_sent;
  int settings_done;
  int cycle_count;

  layer_alpha_composite_convert_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // one layer request; an optional idle burst first, then hold until taken
  task automatic push_layer(logic [31:0] px, logic last, logic eor, logic eoi);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    s_tlast <= last;
    s_tuser <= {eoi, eor};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_layer(px, last, eor, eoi);
    items_sent++;
  endtask

  // stop sending until every owed pixel is back, then let the pipe settle
  task automatic pause_for_results();
    s_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we is lowered before the task returns, so it never drops and rises in one step
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // fresh register set between phases, extremes and junk upper bits included
  task automatic pick_config();
    logic [31:0] val;
    case ($urandom_range(0, 3))
      0: val = 32'h0000_0000;
      1: val = 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
    write_reg(REG_BACKGROUND, val);
    case ($urandom_range(0, 4))
      0: val = 32'd0;
      1: val = 32'd255;
      2: val = 32'd1;
      default: val = $urandom_range(60, 200);
    endcase
    write_reg(REG_THRESHOLD, val | ($urandom & 32'hFFFF_FF00));
    write_reg(REG_PACK_ROW, ($urandom & 32'hFFFF_FFFE) | $urandom_range(0, 1));
    if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, $urandom);
    settings_done++;
  endtask

  // alpha leans on the keep, take and near-edge cases
  function automatic logic [31:0] random_layer();
    logic [7:0] a;
    logic [23:0] rgb;
    case ($urandom_range(0, 6))
      0: a = 8'h00;
      1: a = 8'hFF;
      2: a = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
      default: a = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: rgb = 24'h000000;
      1: rgb = 24'hFFFFFF;
      default: rgb = 24'($urandom);
    endcase
    return {a, rgb};
  endfunction

  // a small image of stacked pixels; now and then a broken one with stray marks
  task automatic run_image();
    int cols;
    int rows;
    int layers;
    bit broken;
    broken = ($urandom_range(0, 9) == 0);
    cols = $urandom_range(1, 10);
    rows = $urandom_range(1, 3);
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        layers = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
        for (int l = 0; l < layers; l++) begin
          if (broken)
            push_layer(random_layer(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          else if (l != layers - 1)
            // inner layer, marks set at random must not matter
            push_layer(random_layer(), 1'b0, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
          else
            push_layer(random_layer(), 1'b1, x == cols - 1,
                       (x == cols - 1) && (y == rows - 1));
        end
      end
    end
    // close any pixel left open by the noise
    if (broken) push_layer(random_layer(), 1'b1, 1'b1, 1'b1);
  endtask

  // result side: check on every taken result, stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_pixel(m_tdata, m_tuser);
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    tracker = new();
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    items_sent = 0;
    settings_done = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset registers: opaque black background, threshold 128, continuous packing
    push_layer(32'h0000_0000, 1'b1, 1'b0, 1'b0); // transparent keeps the background
    push_layer(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0); // opaque white taken as is
    push_layer(32'h00FF_FFFF, 1'b1, 1'b0, 1'b0); // alpha 0, colour bits ignored
    push_layer(32'h80FF_0000, 1'b1, 1'b0, 1'b0); // half red over black
    push_layer(32'h01FF_FFFF, 1'b1, 1'b0, 1'b0);
    push_layer(32'hFE12_3456, 1'b1, 1'b0, 1'b0);
    push_layer(32'hFF00_00FF, 1'b1, 1'b0, 1'b0);
    push_layer(32'hFF00_FF00, 1'b1, 1'b1, 1'b0); // eighth bit flushes, row mark unused
    // three layers, row and image marks on inner layers are ignored
    push_layer(32'hFF20_4060, 1'b0, 1'b1, 1'b1);
    push_layer(32'h7F80_8080, 1'b0, 1'b1, 1'b0);
    push_layer(32'h40FF_FFFF, 1'b1, 1'b0, 1'b0);
    push_layer(32'hFFC0_C0C0, 1'b1, 1'b1, 1'b0); // row end without per-row packing
    push_layer(32'hFF10_1010, 1'b1, 1'b0, 1'b1); // image end flushes a partial byte
    pause_for_results();

    // oversized values keep only their low bits, index 3 goes nowhere
    write_reg(REG_BACKGROUND, 32'h345A_A5F0);
    write_reg(REG_THRESHOLD, 32'hFFFF_FF00);
    write_reg(REG_PACK_ROW, 32'hFFFF_FFFE);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    settings_done++;
    // both layers of the first pixel transparent: alpha comes from the background
    push_layer(32'h0012_3456, 1'b0, 1'b0, 1'b0);
    push_layer(32'h00FF_FFFF, 1'b1, 1'b0, 1'b0);
    push_layer(32'hFF00_0000, 1'b1, 1'b1, 1'b1); // black, threshold 0 keeps it white
    pause_for_results();

    write_reg(REG_THRESHOLD, 32'h0000_00FF);
    write_reg(REG_PACK_ROW, 32'h0000_0001);
    settings_done++;
    push_layer(32'hFF80_8080, 1'b1, 1'b0, 1'b0);
    push_layer(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0); // per-row flush after two bits
    push_layer(32'hFF00_0000, 1'b1, 1'b1, 1'b1);
    pause_for_results();

    // random phases of small images under changing registers
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= QUIET_ITEMS) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 4) != 0);
      pick_config();
      repeat ($urandom_range(1, 4)) run_image();
      pause_for_results();
    end

    idle_on = 1'b0;
    pause_for_results();
    $display("covered %0d layer requests under %0d register settings", items_sent,
             settings_done);
    $display("checked %0d pixels, %0d of them with a packed byte", tracker.pixels_checked,
             tracker.bytes_checked);
    if (tracker.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
